// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- design/mbcrcseq_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus sequencer package
// Request and result types, command codes and the byte-wise CRC-16 fold.
// ----------------------------------------------------------------------------
package mbcrcseq_pkg;

    typedef enum logic [1:0] {
        CMD_RX_BYTE     = 2'd0,
        CMD_TX_DONE     = 2'd1,
        CMD_START_TX    = 2'd2,
        CMD_FRAME_START = 2'd3
    } cmd_t;

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_RESET      = 16'hFFFF;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] rx_byte;
        logic [7:0] tx_length;
    } item_t;

    typedef struct packed {
        logic        write_valid;
        logic [7:0]  write_index;
        logic [7:0]  write_byte;
        logic [15:0] crc_current;
        logic [15:0] crc_one_back;
        logic [15:0] crc_two_back;
        logic        send_valid;
        logic [7:0]  send_index;
        logic        send_finished;
        logic        tx_busy;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- design/mbcrcseq_in_stage.sv -----
// ----------------------------------------------------------------------------
// Modbus sequencer input stage
// Registers one request and releases it when the core takes it.
// ----------------------------------------------------------------------------
module mbcrcseq_in_stage
    import mbcrcseq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_ready,
    input  item_t  item_data,
    input  logic   take,
    output stage_t stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign item_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item_data;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ----- design/mbcrcseq_core.sv -----
// ----------------------------------------------------------------------------
// Modbus sequencer core
// Holds the CRC history and transmit state and registers one result per request.
// ----------------------------------------------------------------------------
module mbcrcseq_core
    import mbcrcseq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  stage_t      stage,
    output logic        take,
    input  logic        crc_seed_we,
    input  logic [15:0] crc_seed_wdata,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result_data
);

    localparam int POS_W = $clog2(BUFFER_DEPTH);

    logic [15:0]      crc_seed_reg;
    logic [15:0]      crc_now_reg,   crc_now_next;
    logic [15:0]      crc_prev_reg,  crc_prev_next;
    logic [15:0]      crc_prev2_reg, crc_prev2_next;
    logic [POS_W-1:0] rx_pos_reg,    rx_pos_next;
    logic [7:0]       tx_next_reg,   tx_next_next;
    logic [7:0]       tx_count_reg,  tx_count_next;
    logic             tx_idle_reg,   tx_idle_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg,    result_next;

    assign take = stage.valid && (!result_valid_reg || result_ready);

    always_comb
    begin
        crc_now_next   = crc_now_reg;
        crc_prev_next  = crc_prev_reg;
        crc_prev2_next = crc_prev2_reg;
        rx_pos_next    = rx_pos_reg;
        tx_next_next   = tx_next_reg;
        tx_count_next  = tx_count_reg;
        tx_idle_next   = tx_idle_reg;
        result_next    = '0;

        case (stage.item.command)
            CMD_RX_BYTE:
            begin
                result_next.write_valid = 1'b1;
                result_next.write_index = 8'(rx_pos_reg);
                result_next.write_byte  = stage.item.rx_byte;
                crc_prev2_next = crc_prev_reg;
                crc_prev_next  = crc_now_reg;
                crc_now_next   = crc_fold(crc_now_reg, stage.item.rx_byte);
                if (rx_pos_reg == POS_W'(BUFFER_DEPTH - 1))
                    rx_pos_next = '0;
                else
                    rx_pos_next = rx_pos_reg + POS_W'(1);
            end
            CMD_TX_DONE:
            begin
                if (!tx_idle_reg)
                begin
                    if (tx_next_reg < tx_count_reg)
                    begin
                        result_next.send_valid = 1'b1;
                        result_next.send_index = tx_next_reg;
                        tx_next_next = tx_next_reg + 8'd1;
                    end
                    else
                    begin
                        tx_count_next = 8'd0;
                        tx_next_next  = 8'd1;
                        tx_idle_next  = 1'b1;
                        result_next.send_finished = 1'b1;
                    end
                end
            end
            CMD_START_TX:
            begin
                if (stage.item.tx_length != 8'd0)
                begin
                    result_next.send_valid = 1'b1;
                    result_next.send_index = 8'd0;
                    tx_count_next = stage.item.tx_length;
                    tx_next_next  = 8'd1;
                    tx_idle_next  = 1'b0;
                end
            end
            CMD_FRAME_START:
            begin
                crc_now_next = crc_seed_reg;
                rx_pos_next  = '0;
            end
            default:
            begin
                crc_now_next = crc_now_reg;
            end
        endcase

        result_next.crc_current  = crc_now_next;
        result_next.crc_one_back = crc_prev_next;
        result_next.crc_two_back = crc_prev2_next;
        result_next.tx_busy      = !tx_idle_next;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg     <= CRC_RESET;
            crc_now_reg      <= CRC_RESET;
            crc_prev_reg     <= '0;
            crc_prev2_reg    <= '0;
            rx_pos_reg       <= '0;
            tx_next_reg      <= 8'd1;
            tx_count_reg     <= 8'd1;
            tx_idle_reg      <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (crc_seed_we)
                crc_seed_reg <= crc_seed_wdata;
            if (take)
            begin
                crc_now_reg   <= crc_now_next;
                crc_prev_reg  <= crc_prev_next;
                crc_prev2_reg <= crc_prev2_next;
                rx_pos_reg    <= rx_pos_next;
                tx_next_reg   <= tx_next_next;
                tx_count_reg  <= tx_count_next;
                tx_idle_reg   <= tx_idle_next;
            end
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

// ----- design/modbus_rx_crc_tx_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Modbus receive CRC and transmit sequencer, top level
// Path: an accepted request is registered in the input stage, then its result is registered in the core.
// Throughput: one request per cycle while results are taken; a held result stalls the input.
// Reset: asynchronous; CRC at 0xFFFF, seed 0xFFFF, history zero, transmit idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_rx_crc_tx_sequencer_top
    import mbcrcseq_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item_data,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result_data,
    input  logic        crc_seed_we,
    input  logic [15:0] crc_seed_wdata
);

    stage_t stage;
    logic   take;
    logic   out_write;
    logic   out_send;
    logic   out_finish;

    mbcrcseq_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .take       (take),
        .stage      (stage)
    );

    mbcrcseq_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .take           (take),
        .crc_seed_we    (crc_seed_we),
        .crc_seed_wdata (crc_seed_wdata),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data)
    );

    assign out_write  = result_valid && result_data.write_valid;
    assign out_send   = result_valid && result_data.send_valid;
    assign out_finish = result_valid && result_data.send_finished;

    `ASSERT_NEVER(a_no_dual_action, clk, rst_n, out_write && (out_send || out_finish))
    `ASSERT_PROP(a_finish_goes_idle, clk, rst_n, out_finish |-> !result_data.tx_busy)
    `ASSERT_PROP(a_send_means_busy, clk, rst_n, out_send |-> result_data.tx_busy)
    `ASSERT_PROP(a_full_stall, clk, rst_n, (stage.valid && result_valid && !result_ready) |-> !item_ready)

endmodule
